// File: sv/gtq_pkg.sv
// Package for the grouped team queue: shared types, codes and default sizes.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gtq_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned GROUPS_DEF      = 4;
  localparam int unsigned GROUP_DEPTH_DEF = 256;

  // Fixed widths of the word fields.
  localparam int ID_W  = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_DEQ = 1'b1
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the input word and start the head read
    logic commit;   // update the queue state and load the output register
  } gtq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;  // output register holds a word not yet taken
  } gtq_stat_t;

endpackage

// File: sv/gtq_ifs.sv
// Valid/ready channel interfaces for the grouped team queue input and output words.
// Depends on gtq_pkg for the field widths.
interface gtq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [gtq_pkg::ID_W-1:0]         group_id;
  logic signed [gtq_pkg::VAL_W-1:0] item_value;

  modport source (output valid, func, group_id, item_value, input ready);
  modport sink   (input valid, func, group_id, item_value, output ready);
endinterface

interface gtq_out_if;
  logic                             valid;
  logic                             ready;
  logic [gtq_pkg::ST_W-1:0]         status;
  logic [gtq_pkg::ID_W-1:0]         out_group;
  logic signed [gtq_pkg::VAL_W-1:0] out_value;

  modport source (output valid, status, out_group, out_value, input ready);
  modport sink   (input valid, status, out_group, out_value, output ready);
endinterface

// File: sv/gtq_ctrl.sv
// Controller of the grouped team queue: a two-state machine that sequences
// capture and commit of each word. Depends on gtq_pkg.
module gtq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  gtq_pkg::gtq_stat_t stat,
  output gtq_pkg::gtq_cmd_t  cmd
);

  gtq_pkg::state_t state;
  gtq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gtq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = gtq_pkg::S_EXEC;
        end
      end
      gtq_pkg::S_EXEC: begin
        if (!stat.out_full || out_ready) begin
          state_next = gtq_pkg::S_IDLE;
        end
      end
      default: state_next = gtq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      gtq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      gtq_pkg::S_EXEC: begin
        cmd.commit = !stat.out_full || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/gtq_dp.sv
// Datapath of the grouped team queue: item store memory, per-group pointers and
// counts, the order queue of groups and the output register. Depends on gtq_pkg.
module gtq_dp #(
  parameter int unsigned GROUPS      = gtq_pkg::GROUPS_DEF,
  parameter int unsigned GROUP_DEPTH = gtq_pkg::GROUP_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gtq_pkg::gtq_cmd_t                cmd,
  output gtq_pkg::gtq_stat_t               stat,
  input  logic                             func,
  input  logic [gtq_pkg::ID_W-1:0]         group_id,
  input  logic signed [gtq_pkg::VAL_W-1:0] item_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [gtq_pkg::ST_W-1:0]         status,
  output logic [gtq_pkg::ID_W-1:0]         out_group,
  output logic signed [gtq_pkg::VAL_W-1:0] out_value
);

  localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PW        = $clog2(GROUP_DEPTH);
  localparam int CW        = $clog2(GROUP_DEPTH + 1);
  localparam int OW        = $clog2(GROUPS + 1);
  localparam int SW        = $clog2(2 * GROUPS + 1);
  localparam int MEM_DEPTH = GROUPS * GROUP_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int VW        = gtq_pkg::VAL_W;

  // Groups outside the configured range fold back by repeated subtraction;
  // a two-bit id needs at most three steps.
  function automatic logic [GW-1:0] fold_group(input logic [gtq_pkg::ID_W-1:0] id);
    int v;
    v = int'(id);
    for (int i = 0; i < 3; i++) begin
      if (v >= int'(GROUPS)) begin
        v = v - int'(GROUPS);
      end
    end
    return GW'(v);
  endfunction

  // Captured word.
  gtq_pkg::func_t      lat_func;
  logic [GW-1:0]       lat_grp;
  logic [VW-1:0]       lat_val;

  // Queue state.
  logic [PW-1:0]       rptr [GROUPS];
  logic [PW-1:0]       wptr [GROUPS];
  logic [CW-1:0]       cnt  [GROUPS];
  logic [GW-1:0]       oq   [GROUPS];
  logic [GW-1:0]       ohead;
  logic [OW-1:0]       ocnt;

  logic [VW-1:0]       mem [MEM_DEPTH];
  logic [VW-1:0]       rd_data;

  // Output register.
  gtq_pkg::status_t    res_status;
  logic [GW-1:0]       res_grp;
  logic [VW-1:0]       res_val;

  logic [GW-1:0]       head_grp;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [GW-1:0]       sel_grp;
  logic [CW-1:0]       sel_cnt;
  logic                is_deq;
  logic                enq_ok;
  logic                enq_join;
  logic                deq_any;
  logic                deq_stale;
  logic                deq_pop;
  logic [SW-1:0]       slot_sum;
  logic [GW-1:0]       slot;
  logic [GW-1:0]       ohead_inc;
  logic [PW-1:0]       wptr_inc;
  logic [PW-1:0]       rptr_inc;
  gtq_pkg::status_t    nxt_status;
  logic [GW-1:0]       nxt_grp;
  logic [VW-1:0]       nxt_val;

  // Head read address, issued in the capture cycle.
  assign head_grp = oq[ohead];
  assign rd_addr  = AW'(int'(head_grp) * int'(GROUP_DEPTH) + int'(rptr[head_grp]));

  assign is_deq   = (lat_func == gtq_pkg::FN_DEQ);
  assign sel_grp  = is_deq ? head_grp : lat_grp;
  assign sel_cnt  = cnt[sel_grp];
  assign wr_addr  = AW'(int'(lat_grp) * int'(GROUP_DEPTH) + int'(wptr[lat_grp]));

  assign enq_ok    = !is_deq && (sel_cnt < CW'(GROUP_DEPTH));
  assign enq_join  = enq_ok && (sel_cnt == '0) && (ocnt < OW'(GROUPS));
  assign deq_any   = is_deq && (ocnt != '0);
  assign deq_stale = deq_any && (sel_cnt == '0);
  assign deq_pop   = deq_stale || (deq_any && (sel_cnt == CW'(1)));

  assign slot_sum  = SW'(ohead) + SW'(ocnt);
  assign slot      = (slot_sum >= SW'(GROUPS)) ? GW'(slot_sum - SW'(GROUPS)) : GW'(slot_sum);
  assign ohead_inc = (ohead == GW'(GROUPS - 1)) ? '0 : ohead + GW'(1);
  assign wptr_inc  = (wptr[sel_grp] == PW'(GROUP_DEPTH - 1)) ? '0 : wptr[sel_grp] + PW'(1);
  assign rptr_inc  = (rptr[sel_grp] == PW'(GROUP_DEPTH - 1)) ? '0 : rptr[sel_grp] + PW'(1);

  always_comb begin
    nxt_grp = '0;
    nxt_val = '0;
    if (is_deq) begin
      if (deq_any && !deq_stale) begin
        nxt_status = gtq_pkg::ST_OK;
        nxt_grp    = sel_grp;
        nxt_val    = rd_data;
      end else begin
        nxt_status = gtq_pkg::ST_EMPTY;
      end
    end else if (enq_ok) begin
      nxt_status = gtq_pkg::ST_OK;
    end else begin
      nxt_status = gtq_pkg::ST_FULL;
    end
  end

  // Item store: written on a committed enqueue, read at the head in the capture cycle.
  always_ff @(posedge clk) begin
    if (cmd.commit && enq_ok) begin
      mem[wr_addr] <= lat_val;
    end
    if (cmd.capture) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lat_func <= gtq_pkg::func_t'(func);
      lat_grp  <= fold_group(group_id);
      lat_val  <= item_value;
    end
    if (cmd.commit) begin
      res_status <= nxt_status;
      res_grp    <= nxt_grp;
      res_val    <= nxt_val;
      if (enq_join) begin
        oq[slot] <= sel_grp;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(GROUPS); i++) begin
        rptr[i] <= '0;
        wptr[i] <= '0;
        cnt[i]  <= '0;
      end
      ohead     <= '0;
      ocnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (enq_ok) begin
          wptr[sel_grp] <= wptr_inc;
          cnt[sel_grp]  <= sel_cnt + CW'(1);
          if (enq_join) begin
            ocnt <= ocnt + OW'(1);
          end
        end
        if (deq_any) begin
          if (!deq_stale) begin
            rptr[sel_grp] <= rptr_inc;
            cnt[sel_grp]  <= sel_cnt - CW'(1);
          end
          if (deq_pop) begin
            ohead <= ohead_inc;
            ocnt  <= ocnt - OW'(1);
          end
        end
      end
    end
  end

  assign stat.out_full = out_valid;
  assign status        = res_status;
  assign out_group     = gtq_pkg::ID_W'(res_grp);
  assign out_value     = res_val;

endmodule

// File: sv/grouped_team_queue.sv
// Top level of the grouped team queue: joins the controller and the datapath.
// Depends on gtq_pkg, gtq_ifs (channel interfaces), gtq_ctrl and gtq_dp.
//
//   Channel  Role   Fields                         Word accepted when
//   in_ch    sink   func, group_id, item_value     in_ch.valid && in_ch.ready
//   out_ch   source status, out_group, out_value   out_ch.valid && out_ch.ready
//
// Each input word is captured, then committed. In the accept cycle the item store is
// read at the head of the group at the front of the order queue. In S_EXEC, once the
// output register is free or being taken, the pointers, counts and order queue are
// updated and the output register loaded. The registered item store read sets this.
// Reset clears the pointers, counts and order queue indexes at once; the item
// store and the order queue entries are not cleared and need no clearing pass.
// A held output word stalls the block only if a second result is ready to load;
// the next input word is still accepted while the first waits.
module grouped_team_queue #(
  parameter int unsigned GROUPS      = gtq_pkg::GROUPS_DEF,
  parameter int unsigned GROUP_DEPTH = gtq_pkg::GROUP_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  gtq_in_if.sink      in_ch,
  gtq_out_if.source   out_ch
);

  // Command and status between the sequencer and the datapath.
  gtq_pkg::gtq_cmd_t  cmd;
  gtq_pkg::gtq_stat_t stat;

  // The controller owns the input handshake and decides when a word commits.
  gtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds all queue storage and drives the output word.
  gtq_dp #(
    .GROUPS      (GROUPS),
    .GROUP_DEPTH (GROUP_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .func       (in_ch.func),
    .group_id   (in_ch.group_id),
    .item_value (in_ch.item_value),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .status     (out_ch.status),
    .out_group  (out_ch.out_group),
    .out_value  (out_ch.out_value)
  );

endmodule

// File: tb/tb_grouped_team_queue.sv
// Self-checking testbench for grouped_team_queue: directed table followed by random bursts.
// Depends on gtq_pkg, gtq_ifs and the RTL of the block; it keeps its own team queue for
// checking and compares every result word in order of arrival.
module tb_grouped_team_queue;

  localparam int GROUPS        = gtq_pkg::GROUPS_DEF;
  localparam int GROUP_DEPTH   = gtq_pkg::GROUP_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int IDLE_PERCENT  = 26;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TIMEOUT_UNITS = 3_000_000;
  localparam int TABLE_ROWS    = 25;

  // Expected content of one result word.
  typedef struct packed {
    gtq_pkg::status_t st;
    logic [1:0]       grp;
    logic [31:0]      val;
  } result_word_t;

  // One row of the directed table. Where known is set, the expected word is
  // typed in; otherwise the team queue below supplies it.
  typedef struct packed {
    gtq_pkg::func_t   fn;
    logic [1:0]       grp;
    logic [31:0]      val;
    logic             known;
    gtq_pkg::status_t st;
    logic [1:0]       exp_grp;
    logic [31:0]      exp_val;
  } table_row_t;

  typedef enum int {
    BURST_MIX,
    BURST_FILL,
    BURST_DRAIN,
    BURST_FLOOD
  } burst_t;

  localparam table_row_t DIRECTED_ROWS [TABLE_ROWS] = '{
    // Dequeue straight after reset finds nothing.
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b1, gtq_pkg::ST_EMPTY, 2'd0, 32'h0},
    // Enqueues carrying the value extremes, each to a new group.
    '{gtq_pkg::FN_ENQ, 2'd0, 32'h8000_0000, 1'b1, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd3, 32'h7FFF_FFFF, 1'b1, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd1, 32'h0000_0000, 1'b1, gtq_pkg::ST_OK, 2'd0, 32'h0},
    // Second member of group 0 slips in ahead of groups 3 and 1.
    '{gtq_pkg::FN_ENQ, 2'd0, 32'hFFFF_FFFF, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd2, 32'h5555_5555, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd3, 32'hAAAA_AAAA, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd1, 32'h1234_5678, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd2, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd3, 32'hFFFF_FFFF, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    // Fully drained: further dequeues report empty whatever they carry.
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b1, gtq_pkg::ST_EMPTY, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd3, 32'hFFFF_FFFF, 1'b1, gtq_pkg::ST_EMPTY, 2'd0, 32'h0},
    // The tail itself belongs to the enqueued group: the item appends there.
    '{gtq_pkg::FN_ENQ, 2'd1, 32'h0000_0011, 1'b1, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd1, 32'h0000_0022, 1'b1, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd2, 32'h0000_0033, 1'b1, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd1, 32'h0000_0044, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd0, 32'h0000_0000, 1'b0, gtq_pkg::ST_OK, 2'd0, 32'h0},
    '{gtq_pkg::FN_DEQ, 2'd2, 32'h8000_0000, 1'b1, gtq_pkg::ST_EMPTY, 2'd0, 32'h0},
    '{gtq_pkg::FN_ENQ, 2'd2, 32'hDEAD_BEEF, 1'b1, gtq_pkg::ST_OK, 2'd0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  gtq_in_if  in_ch();
  gtq_out_if out_ch();

  grouped_team_queue uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Checking copy of the queue: one FIFO of values per group, plus the order
  // in which the groups with waiting members are served.
  logic [31:0] group_fifo [GROUPS][$];
  logic [1:0]  serve_order[$];

  // Result words owed by the block, oldest first.
  result_word_t awaited_words[$];

  int failures   = 0;
  int words_seen = 0;
  int served     = 0;
  int empty_seen = 0;
  int full_seen  = 0;

  // While set, neither side idles.
  bit steady = 1'b0;

  // Applies one input word to the checking copy and returns the word the
  // block must answer with.
  function automatic result_word_t team_queue_response(gtq_pkg::func_t fn,
                                                       logic [1:0] grp_in,
                                                       logic [31:0] val_in);
    result_word_t r;
    int g;
    r = '{st: gtq_pkg::ST_OK, grp: 2'd0, val: 32'd0};
    if (fn == gtq_pkg::FN_ENQ) begin
      g = int'(grp_in) % GROUPS;
      if (group_fifo[g].size() >= GROUP_DEPTH) begin
        // The group is full: the item is dropped and nothing moves.
        r.st = gtq_pkg::ST_FULL;
      end else begin
        // A group with nobody waiting joins the back of the serving order.
        if (group_fifo[g].size() == 0) serve_order.push_back(2'(g));
        group_fifo[g].push_back(val_in);
      end
    end else begin
      if (serve_order.size() == 0) begin
        r.st = gtq_pkg::ST_EMPTY;
      end else begin
        g = int'(serve_order[0]);
        r.grp = 2'(g);
        r.val = group_fifo[g].pop_front();
        // The head group leaves the order once its last member is served.
        if (group_fifo[g].size() == 0) void'(serve_order.pop_front());
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word on the input channel and holds it until it is taken.
  // Idle cycles are inserted at the falling edge before the word is offered.
  // The checking copy advances at the edge where the word is accepted.
  task automatic offer_word(input gtq_pkg::func_t fn, input logic [1:0] grp_in,
                            input logic [31:0] val_in, input bit known,
                            input result_word_t typed_word);
    result_word_t predicted;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= fn;
    in_ch.group_id   <= grp_in;
    in_ch.item_value <= val_in;
    do @(posedge clk); while (!in_ch.ready);
    predicted = team_queue_response(fn, grp_in, val_in);
    awaited_words.push_back(known ? typed_word : predicted);
  endtask

  // Result side: ready starts low and is redrawn at every falling edge so
  // that stalls land on every phase of the block's capture and commit work.
  initial begin : result_ready
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Every accepted result word is matched against the oldest one owed.
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (awaited_words.size() == 0) begin
        $error("result word with none expected: status %0d group %0d value %0h",
               out_ch.status, out_ch.out_group, out_ch.out_value);
        failures++;
      end else begin
        want = awaited_words.pop_front();
        if (out_ch.status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_ch.status);
          failures++;
        end
        if (out_ch.out_group !== want.grp) begin
          $error("out_group: expected %0d, got %0d", want.grp, out_ch.out_group);
          failures++;
        end
        if (out_ch.out_value !== want.val) begin
          $error("out_value: expected %0h, got %0h", want.val, out_ch.out_value);
          failures++;
        end
        case (want.st)
          gtq_pkg::ST_EMPTY: empty_seen++;
          gtq_pkg::ST_FULL:  full_seen++;
          default:           served++;
        endcase
      end
    end
  end

  initial begin : stimulus
    burst_t           mode;
    result_word_t     typed_word;
    int               sent;
    int               phase;
    int               span;
    int               enq_percent;
    int               flood_group;
    gtq_pkg::func_t   fn;
    logic [1:0]       grp_pick;

    // Every input known from time zero; reset held before the first word.
    in_ch.valid      <= 1'b0;
    in_ch.func       <= gtq_pkg::FN_ENQ;
    in_ch.group_id   <= 2'd0;
    in_ch.item_value <= 32'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: walk the table once.
    foreach (DIRECTED_ROWS[i]) begin
      typed_word = '{st: DIRECTED_ROWS[i].st, grp: DIRECTED_ROWS[i].exp_grp,
                     val: DIRECTED_ROWS[i].exp_val};
      offer_word(DIRECTED_ROWS[i].fn, DIRECTED_ROWS[i].grp, DIRECTED_ROWS[i].val,
                 DIRECTED_ROWS[i].known, typed_word);
    end

    // Random part, in bursts of one flavor each. The first burst floods a
    // single group far past its depth so that full-group rejects occur;
    // later bursts mix, fill or drain the queue, with a flood now and then.
    sent  = 0;
    phase = 0;
    typed_word = '{st: gtq_pkg::ST_OK, grp: 2'd0, val: 32'd0};
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 7) == 0) mode = BURST_FLOOD;
      else mode = burst_t'($urandom_range(0, 2));
      span        = (mode == BURST_FLOOD) ? 340 : $urandom_range(10, 60);
      flood_group = $urandom_range(0, GROUPS - 1);
      case (mode)
        BURST_MIX:   enq_percent = 50;
        BURST_FILL:  enq_percent = 80;
        BURST_DRAIN: enq_percent = 12;
        default:     enq_percent = 95;
      endcase
      for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        fn = ($urandom_range(0, 99) < enq_percent) ? gtq_pkg::FN_ENQ : gtq_pkg::FN_DEQ;
        if (mode == BURST_FLOOD && $urandom_range(0, 99) < 97) grp_pick = 2'(flood_group);
        else grp_pick = 2'($urandom_range(0, 3));
        // A stretch in the middle of the run goes without any idling.
        steady = (sent >= 500 && sent < 800);
        offer_word(fn, grp_pick, pick_value(), 1'b0, typed_word);
        sent++;
      end
      phase++;
    end
    steady = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for every owed word, then a few more cycles to catch strays.
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random words in %0d bursts.",
             TABLE_ROWS, RANDOM_ITEMS, phase);
    $display("Results checked: %0d, with %0d ok, %0d empty dequeues, %0d full rejects.",
             words_seen, served, empty_seen, full_seen);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin
    #TIMEOUT_UNITS;
    $display("FAIL");
    $finish;
  end

endmodule
